>>> src/mal_pkg.sv
`timescale 1ns / 1ps

package mal_pkg;

	// Default widths and the modulus after reset
	localparam int MOD_WIDTH_DEF = 31;
	localparam int EXP_WIDTH_DEF = 63;
	localparam longint unsigned MOD_RESET = 64'd1000000007;

	// Register index of the modulus on the configuration port
	localparam logic REG_MODULUS = 1'b0;

	// Request opcodes
	typedef enum logic [2:0] {
		OP_ADD = 3'd0,
		OP_SUB = 3'd1,
		OP_MUL = 3'd2,
		OP_DIV = 3'd3,
		OP_POW = 3'd4,
		OP_INV = 3'd5
	} op_t;

	// Controller states
	typedef enum logic [4:0] {
		ST_IDLE,
		ST_RA_GO,
		ST_RA_RUN,
		ST_RA_WB,
		ST_RB_RUN,
		ST_RB_WB,
		ST_DISPATCH,
		ST_MRES_RUN,
		ST_EU_CHK,
		ST_EU_DIV_RUN,
		ST_EU_DIV_WB,
		ST_EU_MUL_GO,
		ST_EU_MUL_RUN,
		ST_PW_CHK,
		ST_PW_RX_RUN,
		ST_PW_SQ_GO,
		ST_PW_XX_RUN,
		ST_DONE
	} state_t;

	// Divider operand selection
	typedef enum logic [1:0] {
		DIV_A_MOD,
		DIV_B_MOD,
		DIV_EUCLID
	} div_sel_t;

	// Multiplier operand selection
	typedef enum logic [2:0] {
		MUL_AB,
		MUL_UA,
		MUL_AA,
		MUL_QV,
		MUL_SU
	} mul_sel_t;

	// Register writeback codes
	typedef enum logic [3:0] {
		WB_NONE,
		WB_LOAD,
		WB_A_REM,
		WB_B_REM,
		WB_RES_ADD,
		WB_RES_SUB,
		WB_RES_PROD,
		WB_RES_U,
		WB_RES_ZERO,
		WB_INV_INIT,
		WB_POW_INIT,
		WB_EU_DIV,
		WB_EU_MUL,
		WB_U_PROD,
		WB_A_PROD_E
	} wb_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic     div_go;
		div_sel_t div_sel;
		logic     div_step;
		logic     mul_go;
		mul_sel_t mul_sel;
		logic     mul_step;
		wb_t      wb;
	} cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic div_last;
		logic mul_done;
		logic b_zero;
		logic e_zero;
		logic e_one;
		logic e_lsb;
		logic mod_small;
	} sts_t;

endpackage

>>> src/mal_ctrl.sv
`timescale 1ns / 1ps

module mal_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [2:0]    req_type,
	input  mal_pkg::sts_t sts,
	output mal_pkg::cmd_t cmd,
	output logic          busy,
	output logic          result_valid
);

	mal_pkg::state_t state_q, state_nx;
	mal_pkg::op_t    op_q;

	// State and opcode registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mal_pkg::ST_IDLE;
			op_q    <= mal_pkg::OP_ADD;
		end else begin
			state_q <= state_nx;
			if (start && !busy) begin
				op_q <= mal_pkg::op_t'(req_type);
			end
		end
	end

	assign busy         = (state_q != mal_pkg::ST_IDLE);
	assign result_valid = (state_q == mal_pkg::ST_DONE);

	// Sequence the operation
	always_comb begin
		state_nx    = state_q;
		cmd         = '0;
		cmd.div_sel = mal_pkg::DIV_A_MOD;
		cmd.mul_sel = mal_pkg::MUL_AB;
		cmd.wb      = mal_pkg::WB_NONE;
		unique case (state_q)
			mal_pkg::ST_IDLE: begin
				if (start) begin
					if (sts.mod_small) begin
						cmd.wb   = mal_pkg::WB_RES_ZERO;
						state_nx = mal_pkg::ST_DONE;
					end else begin
						cmd.wb   = mal_pkg::WB_LOAD;
						state_nx = mal_pkg::ST_RA_GO;
					end
				end
			end
			mal_pkg::ST_RA_GO: begin
				cmd.div_go  = 1'b1;
				cmd.div_sel = mal_pkg::DIV_A_MOD;
				state_nx    = mal_pkg::ST_RA_RUN;
			end
			mal_pkg::ST_RA_RUN: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					state_nx = mal_pkg::ST_RA_WB;
				end
			end
			mal_pkg::ST_RA_WB: begin
				cmd.wb      = mal_pkg::WB_A_REM;
				cmd.div_go  = 1'b1;
				cmd.div_sel = mal_pkg::DIV_B_MOD;
				state_nx    = mal_pkg::ST_RB_RUN;
			end
			mal_pkg::ST_RB_RUN: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					state_nx = mal_pkg::ST_RB_WB;
				end
			end
			mal_pkg::ST_RB_WB: begin
				cmd.wb   = mal_pkg::WB_B_REM;
				state_nx = mal_pkg::ST_DISPATCH;
			end
			mal_pkg::ST_DISPATCH: begin
				case (op_q) inside
					mal_pkg::OP_ADD: begin
						cmd.wb   = mal_pkg::WB_RES_ADD;
						state_nx = mal_pkg::ST_DONE;
					end
					mal_pkg::OP_SUB: begin
						cmd.wb   = mal_pkg::WB_RES_SUB;
						state_nx = mal_pkg::ST_DONE;
					end
					mal_pkg::OP_MUL: begin
						cmd.mul_go  = 1'b1;
						cmd.mul_sel = mal_pkg::MUL_AB;
						state_nx    = mal_pkg::ST_MRES_RUN;
					end
					mal_pkg::OP_DIV, mal_pkg::OP_INV: begin
						cmd.wb   = mal_pkg::WB_INV_INIT;
						state_nx = mal_pkg::ST_EU_CHK;
					end
					mal_pkg::OP_POW: begin
						cmd.wb   = mal_pkg::WB_POW_INIT;
						state_nx = mal_pkg::ST_PW_CHK;
					end
					default: begin
						cmd.wb   = mal_pkg::WB_RES_ZERO;
						state_nx = mal_pkg::ST_DONE;
					end
				endcase
			end
			mal_pkg::ST_MRES_RUN: begin
				if (sts.mul_done) begin
					cmd.wb   = mal_pkg::WB_RES_PROD;
					state_nx = mal_pkg::ST_DONE;
				end else begin
					cmd.mul_step = 1'b1;
				end
			end
			// Euclid loop: stop when the remainder reaches zero
			mal_pkg::ST_EU_CHK: begin
				if (sts.b_zero) begin
					if (op_q == mal_pkg::OP_DIV) begin
						cmd.mul_go  = 1'b1;
						cmd.mul_sel = mal_pkg::MUL_SU;
						state_nx    = mal_pkg::ST_MRES_RUN;
					end else begin
						cmd.wb   = mal_pkg::WB_RES_U;
						state_nx = mal_pkg::ST_DONE;
					end
				end else begin
					cmd.div_go  = 1'b1;
					cmd.div_sel = mal_pkg::DIV_EUCLID;
					state_nx    = mal_pkg::ST_EU_DIV_RUN;
				end
			end
			mal_pkg::ST_EU_DIV_RUN: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					state_nx = mal_pkg::ST_EU_DIV_WB;
				end
			end
			mal_pkg::ST_EU_DIV_WB: begin
				cmd.wb   = mal_pkg::WB_EU_DIV;
				state_nx = mal_pkg::ST_EU_MUL_GO;
			end
			mal_pkg::ST_EU_MUL_GO: begin
				cmd.mul_go  = 1'b1;
				cmd.mul_sel = mal_pkg::MUL_QV;
				state_nx    = mal_pkg::ST_EU_MUL_RUN;
			end
			mal_pkg::ST_EU_MUL_RUN: begin
				if (sts.mul_done) begin
					cmd.wb   = mal_pkg::WB_EU_MUL;
					state_nx = mal_pkg::ST_EU_CHK;
				end else begin
					cmd.mul_step = 1'b1;
				end
			end
			// Square and multiply, low exponent bit first
			mal_pkg::ST_PW_CHK: begin
				if (sts.e_zero) begin
					cmd.wb   = mal_pkg::WB_RES_U;
					state_nx = mal_pkg::ST_DONE;
				end else if (sts.e_lsb) begin
					cmd.mul_go  = 1'b1;
					cmd.mul_sel = mal_pkg::MUL_UA;
					state_nx    = mal_pkg::ST_PW_RX_RUN;
				end else begin
					cmd.mul_go  = 1'b1;
					cmd.mul_sel = mal_pkg::MUL_AA;
					state_nx    = mal_pkg::ST_PW_XX_RUN;
				end
			end
			mal_pkg::ST_PW_RX_RUN: begin
				if (sts.mul_done) begin
					cmd.wb   = mal_pkg::WB_U_PROD;
					state_nx = mal_pkg::ST_PW_SQ_GO;
				end else begin
					cmd.mul_step = 1'b1;
				end
			end
			mal_pkg::ST_PW_SQ_GO: begin
				// Skip the last squaring, its value is never used
				if (sts.e_one) begin
					cmd.wb   = mal_pkg::WB_RES_U;
					state_nx = mal_pkg::ST_DONE;
				end else begin
					cmd.mul_go  = 1'b1;
					cmd.mul_sel = mal_pkg::MUL_AA;
					state_nx    = mal_pkg::ST_PW_XX_RUN;
				end
			end
			mal_pkg::ST_PW_XX_RUN: begin
				if (sts.mul_done) begin
					cmd.wb   = mal_pkg::WB_A_PROD_E;
					state_nx = mal_pkg::ST_PW_CHK;
				end else begin
					cmd.mul_step = 1'b1;
				end
			end
			mal_pkg::ST_DONE: begin
				state_nx = mal_pkg::ST_IDLE;
			end
			default: begin
				state_nx = mal_pkg::ST_IDLE;
			end
		endcase
	end

	// An accepted request always leaves idle
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted request did not raise busy");

	// The result strobe lasts one cycle and frees the unit
	a_valid_free: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |=> (!busy && !result_valid))
		else $error("result strobe not followed by idle");

	// A result is only shown while a request is in flight
	a_valid_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> busy)
		else $error("result strobe outside a request");

endmodule

>>> src/mal_dp.sv
`timescale 1ns / 1ps

module mal_dp #(
	parameter int MOD_WIDTH = mal_pkg::MOD_WIDTH_DEF,
	parameter int EXP_WIDTH = mal_pkg::EXP_WIDTH_DEF
) (
	input  logic                 clk,
	input  logic [MOD_WIDTH-1:0] modulus,
	input  logic [MOD_WIDTH-1:0] operand_a,
	input  logic [MOD_WIDTH-1:0] operand_b,
	input  logic [EXP_WIDTH-1:0] exponent,
	input  mal_pkg::cmd_t        cmd,
	output mal_pkg::sts_t        sts,
	output logic [MOD_WIDTH-1:0] result
);

	localparam int W  = MOD_WIDTH;
	localparam int CW = $clog2(W);

	// (x + y) mod m for x, y below m
	function automatic logic [W-1:0] add_mod(input logic [W-1:0] x, input logic [W-1:0] y,
			input logic [W-1:0] m);
		logic [W:0] s;
		logic [W:0] d;
		s = {1'b0, x} + {1'b0, y};
		d = s - {1'b0, m};
		return (s >= {1'b0, m}) ? d[W-1:0] : s[W-1:0];
	endfunction

	// (x - y) mod m for x, y below m
	function automatic logic [W-1:0] sub_mod(input logic [W-1:0] x, input logic [W-1:0] y,
			input logic [W-1:0] m);
		logic [W-1:0] d;
		d = x - y;
		return (x >= y) ? d : d + m;
	endfunction

	logic [W-1:0]         a_q, b_q, u_q, v_q, s_q, q_q, res_q;
	logic [EXP_WIDTH-1:0] e_q;

	// Restoring divider
	logic [W-1:0]  dn_q, dr_q, dd_q;
	logic [CW-1:0] dc_q;
	logic [W-1:0]  div_num, div_den;
	logic [W:0]    dtry, ddiff;
	logic          dge;
	logic [W-1:0]  dr_nx;

	// Shift-and-add multiplier
	logic [W-1:0] acc_q, base_q, y_q;
	logic [W-1:0] mul_x, mul_y;
	logic [W-1:0] q_red;

	// Pick divider operands
	always_comb begin
		case (cmd.div_sel)
			mal_pkg::DIV_A_MOD: begin
				div_num = a_q;
				div_den = modulus;
			end
			mal_pkg::DIV_B_MOD: begin
				div_num = b_q;
				div_den = modulus;
			end
			mal_pkg::DIV_EUCLID: begin
				div_num = a_q;
				div_den = b_q;
			end
			default: begin
				div_num = a_q;
				div_den = modulus;
			end
		endcase
	end

	// One quotient bit per step
	assign dtry  = {dr_q, dn_q[W-1]};
	assign ddiff = dtry - {1'b0, dd_q};
	assign dge   = (dtry >= {1'b0, dd_q});
	assign dr_nx = dge ? ddiff[W-1:0] : dtry[W-1:0];

	always_ff @(posedge clk) begin
		if (cmd.div_go) begin
			dn_q <= div_num;
			dr_q <= '0;
			dd_q <= div_den;
			dc_q <= CW'(W - 1);
		end else if (cmd.div_step) begin
			dn_q <= {dn_q[W-2:0], dge};
			dr_q <= dr_nx;
			dc_q <= dc_q - CW'(1);
		end
	end

	// Quotient can equal the modulus, fold it back
	assign q_red = (q_q >= modulus) ? q_q - modulus : q_q;

	// Pick multiplier operands
	always_comb begin
		case (cmd.mul_sel)
			mal_pkg::MUL_AB: begin
				mul_x = a_q;
				mul_y = b_q;
			end
			mal_pkg::MUL_UA: begin
				mul_x = u_q;
				mul_y = a_q;
			end
			mal_pkg::MUL_AA: begin
				mul_x = a_q;
				mul_y = a_q;
			end
			mal_pkg::MUL_QV: begin
				mul_x = q_red;
				mul_y = v_q;
			end
			mal_pkg::MUL_SU: begin
				mul_x = s_q;
				mul_y = u_q;
			end
			default: begin
				mul_x = a_q;
				mul_y = b_q;
			end
		endcase
	end

	// Add the doubled base for each set multiplier bit
	always_ff @(posedge clk) begin
		if (cmd.mul_go) begin
			acc_q  <= '0;
			base_q <= mul_x;
			y_q    <= mul_y;
		end else if (cmd.mul_step) begin
			if (y_q[0]) begin
				acc_q <= add_mod(acc_q, base_q, modulus);
			end
			base_q <= add_mod(base_q, base_q, modulus);
			y_q    <= y_q >> 1;
		end
	end

	// Write back working registers
	always_ff @(posedge clk) begin
		case (cmd.wb)
			mal_pkg::WB_LOAD: begin
				a_q <= operand_a;
				b_q <= operand_b;
				e_q <= exponent;
			end
			mal_pkg::WB_A_REM:    a_q   <= dr_q;
			mal_pkg::WB_B_REM:    b_q   <= dr_q;
			mal_pkg::WB_RES_ADD:  res_q <= add_mod(a_q, b_q, modulus);
			mal_pkg::WB_RES_SUB:  res_q <= sub_mod(a_q, b_q, modulus);
			mal_pkg::WB_RES_PROD: res_q <= acc_q;
			mal_pkg::WB_RES_U:    res_q <= u_q;
			mal_pkg::WB_RES_ZERO: res_q <= '0;
			mal_pkg::WB_INV_INIT: begin
				s_q <= a_q;
				a_q <= b_q;
				b_q <= modulus;
				u_q <= W'(1);
				v_q <= '0;
			end
			mal_pkg::WB_POW_INIT: u_q <= W'(1);
			mal_pkg::WB_EU_DIV: begin
				a_q <= b_q;
				b_q <= dr_q;
				q_q <= dn_q;
			end
			mal_pkg::WB_EU_MUL: begin
				u_q <= v_q;
				v_q <= sub_mod(u_q, acc_q, modulus);
			end
			mal_pkg::WB_U_PROD: u_q <= acc_q;
			mal_pkg::WB_A_PROD_E: begin
				a_q <= acc_q;
				e_q <= e_q >> 1;
			end
			default: begin
			end
		endcase
	end

	// Report status
	always_comb begin
		sts.div_last  = (dc_q == '0);
		sts.mul_done  = (y_q == '0);
		sts.b_zero    = (b_q == '0);
		sts.e_zero    = (e_q == '0);
		sts.e_one     = (e_q == EXP_WIDTH'(1));
		sts.e_lsb     = e_q[0];
		sts.mod_small = (modulus < W'(2));
	end

	assign result = res_q;

endmodule

>>> src/modular_arithmetic_alu.sv
`timescale 1ns / 1ps

// Modular arithmetic unit: add, subtract, multiply, divide, power and inverse
// over the modulus held in its one configuration register.
// Request channel: drive req_type, operand_a, operand_b and exponent with start;
// the request is taken on a clock edge where start is high and busy is low.
// Result channel: result_valid is high for exactly one cycle with result; the
// receiver cannot stall it, so it must take the value in that cycle.
// Configuration: APB-style write of the modulus at byte address 0; write it only
// while busy is low, as the block does not enforce this. pready is tied high.
// Sequence: both operands are first reduced modulo the modulus on the shared
// bit-serial divider. Add and subtract then write the result, and an unused
// opcode returns zero; multiply runs the shift-and-add multiplier; power
// squares and multiplies per exponent bit, low bit first, skipping the
// last squaring; inverse and divide run Euclid steps of a divide and a
// multiply each, and divide ends with one more multiply. A modulus below two
// gives a zero result without reduction. Multiplies and divides take one
// bit a cycle.
// One request is in flight at a time; busy falls the cycle after result_valid.
// Reset loads the modulus with 1000000007 and returns the controller to idle.
module modular_arithmetic_alu #(
	parameter int MOD_WIDTH = mal_pkg::MOD_WIDTH_DEF,
	parameter int EXP_WIDTH = mal_pkg::EXP_WIDTH_DEF,
	localparam int DATA_W   = (MOD_WIDTH > 32) ? 64 : 32,
	localparam int ADDR_W   = (MOD_WIDTH > 32) ? 4 : 3
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [ADDR_W-1:0]    paddr,
	input  logic [DATA_W-1:0]    pwdata,
	output logic [DATA_W-1:0]    prdata,
	output logic                 pready,
	input  logic                 start,
	output logic                 busy,
	input  logic [2:0]           req_type,
	input  logic [MOD_WIDTH-1:0] operand_a,
	input  logic [MOD_WIDTH-1:0] operand_b,
	input  logic [EXP_WIDTH-1:0] exponent,
	output logic                 result_valid,
	output logic [MOD_WIDTH-1:0] result
);

	logic [MOD_WIDTH-1:0] mod_q;
	logic                 reg_idx;
	mal_pkg::cmd_t        cmd;
	mal_pkg::sts_t        sts;

	assign pready  = 1'b1;
	assign reg_idx = paddr[ADDR_W-1];

	// Modulus register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mod_q <= MOD_WIDTH'(mal_pkg::MOD_RESET);
		end else if (psel && penable && pwrite && pready
				&& (reg_idx == mal_pkg::REG_MODULUS)) begin
			mod_q <= pwdata[MOD_WIDTH-1:0];
		end
	end

	// Read back
	assign prdata = (reg_idx == mal_pkg::REG_MODULUS) ? DATA_W'(mod_q) : '0;

	mal_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.req_type     (req_type),
		.sts          (sts),
		.cmd          (cmd),
		.busy         (busy),
		.result_valid (result_valid)
	);

	mal_dp #(
		.MOD_WIDTH (MOD_WIDTH),
		.EXP_WIDTH (EXP_WIDTH)
	) u_dp (
		.clk       (clk),
		.modulus   (mod_q),
		.operand_a (operand_a),
		.operand_b (operand_b),
		.exponent  (exponent),
		.cmd       (cmd),
		.sts       (sts),
		.result    (result)
	);

endmodule
